// ===== hw/rtl/s2xy_pkg.sv =====
// types, constants and the linearisation table for the srgb to cie xy block
`timescale 1ns / 1ps

package s2xy_pkg;

   // linear channel precision
   localparam int LINEAR_BITS = 16;
   // matrix coefficients are in units of 1/10000, largest 9505
   localparam int COEF_BITS = 14;
   // X, Y and Z each stay below 2^(LINEAR_BITS+14)
   localparam int XYZ_BITS = LINEAR_BITS + COEF_BITS;
   // X+Y+Z stays below 2^(LINEAR_BITS+15)
   localparam int SUM_BITS = XYZ_BITS + 1;
   localparam int RATIO_BITS = 16;
   localparam int CHAN_BITS = 8;
   localparam int TABLE_DEPTH = 1 << CHAN_BITS;

   // srgb to xyz matrix
   localparam logic [COEF_BITS-1:0] COEF_XR = COEF_BITS'(4124);
   localparam logic [COEF_BITS-1:0] COEF_XG = COEF_BITS'(3576);
   localparam logic [COEF_BITS-1:0] COEF_XB = COEF_BITS'(1805);
   localparam logic [COEF_BITS-1:0] COEF_YR = COEF_BITS'(2126);
   localparam logic [COEF_BITS-1:0] COEF_YG = COEF_BITS'(7152);
   localparam logic [COEF_BITS-1:0] COEF_YB = COEF_BITS'(722);
   localparam logic [COEF_BITS-1:0] COEF_ZR = COEF_BITS'(193);
   localparam logic [COEF_BITS-1:0] COEF_ZG = COEF_BITS'(1192);
   localparam logic [COEF_BITS-1:0] COEF_ZB = COEF_BITS'(9505);

   // transfer curve constants, fixed point
   localparam int Q_FRAC = 30;
   localparam longint unsigned Q_ONE = 64'd1 << Q_FRAC;
   localparam longint unsigned LIN_KNEE = 64'd10;
   localparam longint unsigned LIN_DIVISOR = 64'd329460;
   localparam longint unsigned PWR_SCALE = 64'd1000;
   localparam longint unsigned PWR_OFFSET = 64'd14025;
   localparam longint unsigned PWR_DIVISOR = 64'd269025;

   typedef logic [LINEAR_BITS-1:0] lin_type;
   typedef logic [TABLE_DEPTH-1:0][LINEAR_BITS-1:0] lin_table_type;

   function automatic longint unsigned q_mul(input longint unsigned a,
                                             input longint unsigned b);
      return (a * b) >> Q_FRAC;
   endfunction

   function automatic longint unsigned q_pow5(input longint unsigned r);
      longint unsigned p;
      p = q_mul(r, r);
      p = q_mul(p, r);
      p = q_mul(p, r);
      return q_mul(p, r);
   endfunction

   // evaluated at elaboration only
   function automatic lin_table_type build_lin_table();
      lin_table_type tbl;
      longint unsigned c;
      longint unsigned lin;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned r;
      longint unsigned cand;
      longint unsigned maxv;
      maxv = (64'd1 << LINEAR_BITS) - 64'd1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         c = 64'(i);
         if (c <= LIN_KNEE) begin
            lin = ((c * 64'd100) << LINEAR_BITS) / LIN_DIVISOR;
         end else begin
            t = ((PWR_SCALE * c + PWR_OFFSET) << Q_FRAC) / PWR_DIVISOR;
            if (t > Q_ONE) begin
               t = Q_ONE;
            end
            t2 = q_mul(t, t);
            r = 64'd0;
            // bitwise search for the fifth root of t^2, i.e. t^0.4
            for (int b = Q_FRAC; b >= 0; b--) begin
               cand = r | (64'd1 << b);
               if (cand <= Q_ONE) begin
                  if (q_pow5(cand) <= t2) begin
                     r = cand;
                  end
               end
            end
            lin = q_mul(t2, r) >> (Q_FRAC - LINEAR_BITS);
         end
         if (lin > maxv) begin
            lin = maxv;
         end
         tbl[i] = lin[LINEAR_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

   // one step of the restoring divider for both ratios
   typedef struct packed {
      logic [SUM_BITS-1:0]   rem_x;
      logic [SUM_BITS-1:0]   rem_y;
      logic [SUM_BITS-1:0]   den;
      logic [RATIO_BITS-1:0] quo_x;
      logic [RATIO_BITS-1:0] quo_y;
      logic                  black;
   } div_type;

endpackage

// ===== hw/rtl/s2xy_ifs.sv =====
// request and response channel interfaces for the srgb to cie xy block
`timescale 1ns / 1ps

interface s2xy_req_if;
   logic                                valid;
   logic                                ready;
   logic [s2xy_pkg::CHAN_BITS-1:0]      red;
   logic [s2xy_pkg::CHAN_BITS-1:0]      green;
   logic [s2xy_pkg::CHAN_BITS-1:0]      blue;

   modport source(output valid, output red, output green, output blue, input ready);
   modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface s2xy_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [s2xy_pkg::RATIO_BITS-1:0]     chroma_x;
   logic [s2xy_pkg::RATIO_BITS-1:0]     chroma_y;
   logic                                black_input;

   modport source(output valid, output chroma_x, output chroma_y, output black_input,
                  input ready);
   modport sink(input valid, input chroma_x, input chroma_y, input black_input,
                output ready);
endinterface

// ===== hw/rtl/srgb_to_cie_xy.sv =====
// top level: srgb byte triple to cie 1931 xy chromaticity, fully pipelined
`timescale 1ns / 1ps

// Takes one sRGB pixel per cycle on req_ch and returns its CIE xy chromaticity
// on rsp_ch, scaled by 65536 and truncated, one result per pixel in order.
// Between an input transfer and its result lie one stage for the transfer
// curve lookup, one for the XYZ matrix, one for X+Y+Z and the setup of the
// divider, sixteen restoring divider stages (one quotient bit each, x and y
// side by side) and the output register. The whole pipe moves as one: it
// only holds when the output register is full and rsp_ch.ready is low, and
// then req_ch.ready drops in the same cycle, so nothing is lost or repeated.
// An all-black pixel gives zero chromaticity with black_input set.
module srgb_to_cie_xy (
   input logic       clock,
   input logic       reset,
   s2xy_req_if.sink  req_ch,
   s2xy_rsp_if.source rsp_ch
);

   localparam int DIV_STEPS = s2xy_pkg::RATIO_BITS;
   // lookup, matrix, divider setup plus steps, output
   localparam int NUM_STAGES = 3 + DIV_STEPS + 1;
   localparam int STG_LIN = 0;
   localparam int STG_XYZ = 1;
   localparam int STG_DIV = 2;
   localparam int STG_OUT = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic                  stall;
   logic                  advance;

   // linearised channels
   s2xy_pkg::lin_type red_lin_ff;
   s2xy_pkg::lin_type green_lin_ff;
   s2xy_pkg::lin_type blue_lin_ff;

   // tristimulus values
   logic [s2xy_pkg::XYZ_BITS-1:0] cx_ff;
   logic [s2xy_pkg::XYZ_BITS-1:0] cy_ff;
   logic [s2xy_pkg::XYZ_BITS-1:0] cz_ff;
   logic [s2xy_pkg::XYZ_BITS-1:0] cx_in;
   logic [s2xy_pkg::XYZ_BITS-1:0] cy_in;
   logic [s2xy_pkg::XYZ_BITS-1:0] cz_in;

   // divider pipe, entry 0 is the setup stage
   s2xy_pkg::div_type div_ff [DIV_STEPS+1];
   s2xy_pkg::div_type div_setup_in;

   // output register
   logic [s2xy_pkg::RATIO_BITS-1:0] chroma_x_ff;
   logic [s2xy_pkg::RATIO_BITS-1:0] chroma_y_ff;
   logic                            black_ff;

   // one restoring step: shift remainder, subtract if it fits
   function automatic s2xy_pkg::div_type div_step(input s2xy_pkg::div_type d);
      s2xy_pkg::div_type  o;
      logic [s2xy_pkg::SUM_BITS:0] sx;
      logic [s2xy_pkg::SUM_BITS:0] sy;
      logic [s2xy_pkg::SUM_BITS:0] dn;
      o  = d;
      sx = {d.rem_x, 1'b0};
      sy = {d.rem_y, 1'b0};
      dn = {1'b0, d.den};
      if (sx >= dn) begin
         sx = sx - dn;
      end
      if (sy >= dn) begin
         sy = sy - dn;
      end
      o.rem_x = sx[s2xy_pkg::SUM_BITS-1:0];
      o.rem_y = sy[s2xy_pkg::SUM_BITS-1:0];
      o.quo_x = {d.quo_x[s2xy_pkg::RATIO_BITS-2:0], ({d.rem_x, 1'b0} >= dn)};
      o.quo_y = {d.quo_y[s2xy_pkg::RATIO_BITS-2:0], ({d.rem_y, 1'b0} >= dn)};
      return o;
   endfunction

   // the pipe only holds on a full output register that is not taken
   assign stall   = vld_ff[STG_OUT] && !rsp_ch.ready;
   assign advance = !stall;

   assign req_ch.ready = advance;

   always_comb begin
      vld_in = vld_ff;
      if (advance) begin
         vld_in = {vld_ff[NUM_STAGES-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // transfer curve: constant table lookup
   always_ff @(posedge clock) begin
      if (advance) begin
         red_lin_ff   <= s2xy_pkg::LIN_TABLE[req_ch.red];
         green_lin_ff <= s2xy_pkg::LIN_TABLE[req_ch.green];
         blue_lin_ff  <= s2xy_pkg::LIN_TABLE[req_ch.blue];
      end
   end

   // matrix by constant coefficients, no term overflows XYZ_BITS
   always_comb begin
      cx_in = s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_XR) * s2xy_pkg::XYZ_BITS'(red_lin_ff)
            + s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_XG) * s2xy_pkg::XYZ_BITS'(green_lin_ff)
            + s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_XB) * s2xy_pkg::XYZ_BITS'(blue_lin_ff);
      cy_in = s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_YR) * s2xy_pkg::XYZ_BITS'(red_lin_ff)
            + s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_YG) * s2xy_pkg::XYZ_BITS'(green_lin_ff)
            + s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_YB) * s2xy_pkg::XYZ_BITS'(blue_lin_ff);
      cz_in = s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_ZR) * s2xy_pkg::XYZ_BITS'(red_lin_ff)
            + s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_ZG) * s2xy_pkg::XYZ_BITS'(green_lin_ff)
            + s2xy_pkg::XYZ_BITS'(s2xy_pkg::COEF_ZB) * s2xy_pkg::XYZ_BITS'(blue_lin_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
   end

   // divider setup: every coefficient is positive, so a non-zero sum means
   // Y+Z > 0 and X < sum, Y < sum; the quotients then fit in 16 bits
   always_comb begin
      div_setup_in.den   = s2xy_pkg::SUM_BITS'(cx_ff) + s2xy_pkg::SUM_BITS'(cy_ff)
                         + s2xy_pkg::SUM_BITS'(cz_ff);
      div_setup_in.rem_x = s2xy_pkg::SUM_BITS'(cx_ff);
      div_setup_in.rem_y = s2xy_pkg::SUM_BITS'(cy_ff);
      div_setup_in.quo_x = '0;
      div_setup_in.quo_y = '0;
      div_setup_in.black = (div_setup_in.den == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0] <= div_setup_in;
      end
   end

   // one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[k+1] <= div_step(div_ff[k]);
         end
      end
   end

   // output register, black forces zero chromaticity
   always_ff @(posedge clock) begin
      if (advance) begin
         black_ff <= div_ff[DIV_STEPS].black;
         if (div_ff[DIV_STEPS].black) begin
            chroma_x_ff <= '0;
            chroma_y_ff <= '0;
         end else begin
            chroma_x_ff <= div_ff[DIV_STEPS].quo_x;
            chroma_y_ff <= div_ff[DIV_STEPS].quo_y;
         end
      end
   end

   assign rsp_ch.valid       = vld_ff[STG_OUT];
   assign rsp_ch.chroma_x    = chroma_x_ff;
   assign rsp_ch.chroma_y    = chroma_y_ff;
   assign rsp_ch.black_input = black_ff;

   // a transfer in always lands in the lookup stage
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[STG_LIN])
      else $error("accepted pixel did not enter the pipe");

   // matrix stage only fills from the lookup stage
   a_xyz_source: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG_XYZ] && !$past(stall) |-> $past(vld_ff[STG_LIN]))
      else $error("matrix stage filled without a pixel");

   // remainders must be below the divisor at the last divider stage
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG_DIV + DIV_STEPS] && !div_ff[DIV_STEPS].black |->
         div_ff[DIV_STEPS].rem_x < div_ff[DIV_STEPS].den &&
         div_ff[DIV_STEPS].rem_y < div_ff[DIV_STEPS].den)
      else $error("divider remainder out of range");

   // x + y < 1 for any non-black pixel since Z > 0
   a_xy_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.black_input |->
         ({1'b0, rsp_ch.chroma_x} + {1'b0, rsp_ch.chroma_y}) < {1'b1, 16'd0})
      else $error("chromaticity sum reached one");

   a_black_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.black_input |->
         rsp_ch.chroma_x == '0 && rsp_ch.chroma_y == '0)
      else $error("black pixel gave non-zero chromaticity");

endmodule
